@@ hw/rtl/event_histogram_accumulator_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the event histogram accumulator
// ---------------------------------------------------------------------------
`ifndef EVENT_HISTOGRAM_ACCUMULATOR_ASSERT_SVH
`define EVENT_HISTOGRAM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/eha_pkg.sv @@
// ---------------------------------------------------------------------------
// eha_pkg
// Shared types, codes and arithmetic helpers of the histogram accumulator.
// ---------------------------------------------------------------------------
package eha_pkg;

    localparam int NBINS_DEFAULT = 64;

    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_CLOSE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] CFG_BIN_MIN       = 2'd0;
    localparam logic [1:0] CFG_BIN_INV_WIDTH = 2'd1;
    localparam logic [1:0] CFG_BINS_IN_USE   = 2'd2;

    localparam logic [31:0] BIN_MIN_RST       = 32'd0;
    localparam logic [31:0] BIN_INV_WIDTH_RST = 32'd65536;
    localparam logic [6:0]  BINS_IN_USE_RST   = 7'd64;

    // classified request, front to back
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               hit;
        logic [31:0]        bin;
        logic [5:0]         sel;
    } cmd_t;

    // one bin's stored sums
    typedef struct packed {
        logic signed [47:0] xs;
        logic signed [47:0] ey;
        logic signed [47:0] ty;
        logic [63:0]        tsq;
        logic [31:0]        hits;
    } entry_t;

    function automatic logic [31:0] active_bins(logic [6:0] biu, logic [31:0] nb);
        logic [31:0] b;
        b = {25'd0, biu};
        return (b > nb) ? nb : b;
    endfunction

    function automatic logic signed [47:0] sat48_add(logic signed [47:0] a,
                                                     logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47])
            return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        return s[47:0];
    endfunction

    function automatic logic [63:0] satu64_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

@@ hw/rtl/eha_ram.sv @@
// ---------------------------------------------------------------------------
// eha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module eha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/eha_queue.sv @@
// ---------------------------------------------------------------------------
// eha_queue
// Two-entry request queue between the classify front and the update back.
// ---------------------------------------------------------------------------
module eha_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  eha_pkg::cmd_t push_data,
    input  logic          pop,
    output eha_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import eha_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;

endmodule

@@ hw/rtl/eha_front.sv @@
// ---------------------------------------------------------------------------
// eha_front
// Takes requests, computes the bin from x and the config, queues the result.
// ---------------------------------------------------------------------------
module eha_front #(
    parameter int NBINS = eha_pkg::NBINS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_y_value,
    input  logic [5:0]         s_bin_select,
    input  logic signed [31:0] bin_min,
    input  logic [31:0]        bin_inv_width,
    input  logic [6:0]         bins_in_use,
    input  logic               clr_busy,
    input  logic               q_full,
    output logic               q_push,
    output eha_pkg::cmd_t      q_data
);
    import eha_pkg::*;

    logic               stg_valid_reg, stg_valid_next;
    logic [1:0]         stg_mode_reg;
    logic signed [31:0] stg_x_reg;
    logic signed [31:0] stg_y_reg;
    logic [5:0]         stg_sel_reg;

    logic signed [32:0] diff;
    logic [63:0]        prod;
    logic [31:0]        act;

    assign s_ready = !clr_busy && (!stg_valid_reg || !q_full);
    assign q_push  = stg_valid_reg && !q_full;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (q_push) stg_valid_next = 1'b0;
        if (s_valid && s_ready) stg_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
        if (s_valid && s_ready) begin
            stg_mode_reg <= s_mode;
            stg_x_reg    <= s_x_value;
            stg_y_reg    <= s_y_value;
            stg_sel_reg  <= s_bin_select;
        end
    end

    // floor((x - min) * inv / 2^32): negative offsets miss unless inv is zero
    always_comb begin
        diff = 33'(stg_x_reg) - 33'(bin_min);
        prod = 64'(diff[31:0]) * 64'(bin_inv_width);
        act  = active_bins(bins_in_use, 32'(NBINS));
        q_data.mode = stg_mode_reg;
        q_data.x    = stg_x_reg;
        q_data.y    = stg_y_reg;
        q_data.sel  = stg_sel_reg;
        q_data.bin  = 32'd0;
        q_data.hit  = 1'b0;
        if (!diff[32]) begin
            q_data.bin = prod[63:32];
            q_data.hit = prod[63:32] < act;
        end else if (bin_inv_width == 32'd0) begin
            q_data.hit = act != 32'd0;
        end
    end

endmodule

@@ hw/rtl/eha_back.sv @@
// ---------------------------------------------------------------------------
// eha_back
// Executes queued requests against the bin memory and drives the result.
// ---------------------------------------------------------------------------
module eha_back #(
    parameter int NBINS = eha_pkg::NBINS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    output logic               q_pop,
    input  eha_pkg::cmd_t      q_data,
    input  logic [6:0]         bins_in_use,
    output logic               clr_busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_in_range,
    output logic [5:0]         m_bin_index,
    output logic signed [47:0] m_sum_of_x,
    output logic signed [47:0] m_sum_of_y,
    output logic [63:0]        m_sum_of_y_squared,
    output logic [31:0]        m_hit_count,
    output logic [31:0]        m_closed_events
);
    import eha_pkg::*;

    localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int CNT_W  = $clog2(NBINS + 1);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NBINS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMUL  = 3'd4;
    localparam logic [2:0] S_CWR   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [31:0]       evt_reg, evt_next;
    entry_t            ent_reg, ent_next;
    logic [63:0]       sq_reg, sq_next;

    logic               mv_reg, mv_next;
    logic               min_reg, min_next;
    logic [5:0]         midx_reg, midx_next;
    logic signed [47:0] msx_reg, msx_next;
    logic signed [47:0] msy_reg, msy_next;
    logic [63:0]        msq_reg, msq_next;
    logic [31:0]        mhit_reg, mhit_next;
    logic [31:0]        mevt_reg, mevt_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    entry_t            wr_data, rd_data;

    logic              out_free;
    logic [CNT_W-1:0]  act;
    logic [CNT_W-1:0]  walk_inc;
    logic [31:0]       sel_ext;
    logic              sel_ok;
    logic [47:0]       mag;
    entry_t            upd;

    eha_ram #(.WIDTH($bits(entry_t)), .DEPTH(NBINS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !mv_reg || m_ready;
    assign act      = CNT_W'(active_bins(bins_in_use, 32'(NBINS)));
    assign walk_inc = walk_reg + CNT_W'(1);
    assign clr_busy = state_reg == S_CLEAR;
    assign q_pop    = state_reg == S_IDLE && !q_empty;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        walk_next  = walk_reg;
        clr_next   = clr_reg;
        evt_next   = evt_reg;
        ent_next   = ent_reg;
        sq_next    = sq_reg;
        mv_next    = mv_reg && !m_ready;
        min_next   = min_reg;
        midx_next  = midx_reg;
        msx_next   = msx_reg;
        msy_next   = msy_reg;
        msq_next   = msq_reg;
        mhit_next  = mhit_reg;
        mevt_next  = mevt_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        upd        = rd_data;
        mag        = '0;

        sel_ext = {26'd0, cmd_reg.sel};
        sel_ok  = sel_ext < 32'(NBINS);

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (!q_empty) begin
                    cmd_next   = q_data;
                    state_next = S_DONE;
                    case (q_data.mode)
                        MODE_FILL: begin
                            if (q_data.hit) begin
                                rd_en      = 1'b1;
                                rd_addr    = q_data.bin[ADDR_W-1:0];
                                state_next = S_FILL;
                            end
                        end
                        MODE_CLOSE: begin
                            if (evt_reg != '1) evt_next = evt_reg + 32'd1;
                            walk_next = '0;
                            if (act != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_CMUL;
                            end
                        end
                        MODE_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'({26'd0, q_data.sel});
                            state_next = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                if (out_free) begin
                    upd.xs = sat48_add(rd_data.xs, 48'(cmd_reg.x));
                    upd.ey = sat48_add(rd_data.ey, 48'(cmd_reg.y));
                    if (rd_data.hits != '1) upd.hits = rd_data.hits + 32'd1;
                    wr_en      = 1'b1;
                    wr_addr    = cmd_reg.bin[ADDR_W-1:0];
                    wr_data    = upd;
                    mv_next    = 1'b1;
                    min_next   = 1'b1;
                    midx_next  = cmd_reg.bin[5:0];
                    msx_next   = '0;
                    msy_next   = '0;
                    msq_next   = '0;
                    mhit_next  = '0;
                    mevt_next  = evt_reg;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    min_next   = sel_ok;
                    midx_next  = cmd_reg.sel;
                    msx_next   = sel_ok ? rd_data.xs : '0;
                    msy_next   = sel_ok ? rd_data.ty : '0;
                    msq_next   = sel_ok ? rd_data.tsq : '0;
                    mhit_next  = sel_ok ? rd_data.hits : '0;
                    mevt_next  = evt_reg;
                    state_next = S_IDLE;
                end
            end
            S_CMUL: begin
                // square of the event sum; magnitudes past 32 bits saturate
                mag      = rd_data.ey[47] ? 48'(-rd_data.ey) : 48'(rd_data.ey);
                ent_next = rd_data;
                sq_next  = (mag[47:32] != '0) ? '1 : 64'(mag[31:0]) * 64'(mag[31:0]);
                state_next = S_CWR;
            end
            S_CWR: begin
                upd     = ent_reg;
                upd.ty  = sat48_add(ent_reg.ty, ent_reg.ey);
                upd.tsq = satu64_add(ent_reg.tsq, sq_reg);
                upd.ey  = '0;
                wr_en   = 1'b1;
                wr_addr = walk_reg[ADDR_W-1:0];
                wr_data = upd;
                if (walk_inc < act) begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_inc[ADDR_W-1:0];
                    walk_next  = walk_inc;
                    state_next = S_CMUL;
                end else begin
                    walk_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    min_next   = cmd_reg.mode == MODE_CLOSE;
                    midx_next  = '0;
                    msx_next   = '0;
                    msy_next   = '0;
                    msq_next   = '0;
                    mhit_next  = '0;
                    mevt_next  = evt_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            walk_reg  <= '0;
            evt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            walk_reg  <= walk_next;
            evt_reg   <= evt_next;
            mv_reg    <= mv_next;
        end
        cmd_reg  <= cmd_next;
        ent_reg  <= ent_next;
        sq_reg   <= sq_next;
        min_reg  <= min_next;
        midx_reg <= midx_next;
        msx_reg  <= msx_next;
        msy_reg  <= msy_next;
        msq_reg  <= msq_next;
        mhit_reg <= mhit_next;
        mevt_reg <= mevt_next;
    end

    assign m_valid            = mv_reg;
    assign m_in_range         = min_reg;
    assign m_bin_index        = midx_reg;
    assign m_sum_of_x         = msx_reg;
    assign m_sum_of_y         = msy_reg;
    assign m_sum_of_y_squared = msq_reg;
    assign m_hit_count        = mhit_reg;
    assign m_closed_events    = mevt_reg;

endmodule

@@ hw/rtl/event_histogram_accumulator.sv @@
// ---------------------------------------------------------------------------
// event_histogram_accumulator
// Binned x/y accumulator with per-event y totals and squared totals.
//
// Input channel s_*: mode 0 fill (x, y), 1 close event, 2 read bin_select.
// Result channel m_*: one result per request, in request order.
// Config port: cfg_wr_en/cfg_index/cfg_wr_data, index 0 bin_min,
// 1 bin_inv_width, 2 bins_in_use; write only while idle.
// After reset a clear pass writes every bin to zero while s_ready stays low.
// The front registers a request and computes its bin combinationally from
// the registered values, then queues it (two entries). The back does one
// bin-memory read-modify-write per fill and only reads for a read; it
// finishes each request before it takes the next from the queue. A close
// walks the bins in use, reading, squaring and writing back each in turn.
// When m_ready is low the result register holds; the queue and front keep
// taking requests until the queue and the front stage are both full.
// ---------------------------------------------------------------------------
module event_histogram_accumulator #(
    parameter int NBINS = eha_pkg::NBINS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_y_value,
    input  logic [5:0]         s_bin_select,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_in_range,
    output logic [5:0]         m_bin_index,
    output logic signed [47:0] m_sum_of_x,
    output logic signed [47:0] m_sum_of_y,
    output logic [63:0]        m_sum_of_y_squared,
    output logic [31:0]        m_hit_count,
    output logic [31:0]        m_closed_events,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data
);
    import eha_pkg::*;

    `include "event_histogram_accumulator_assert.svh"

    logic signed [31:0] bin_min_reg;
    logic [31:0]        inv_reg;
    logic [6:0]         biu_reg;

    logic clr_busy, q_push, q_pop, q_full, q_empty;
    cmd_t push_data, pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_min_reg <= BIN_MIN_RST;
            inv_reg     <= BIN_INV_WIDTH_RST;
            biu_reg     <= BINS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BIN_MIN:       bin_min_reg <= cfg_wr_data;
                CFG_BIN_INV_WIDTH: inv_reg     <= cfg_wr_data;
                CFG_BINS_IN_USE:   biu_reg     <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    eha_front #(.NBINS(NBINS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_x_value     (s_x_value),
        .s_y_value     (s_y_value),
        .s_bin_select  (s_bin_select),
        .bin_min       (bin_min_reg),
        .bin_inv_width (inv_reg),
        .bins_in_use   (biu_reg),
        .clr_busy      (clr_busy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data)
    );

    eha_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    eha_back #(.NBINS(NBINS)) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_pop              (q_pop),
        .q_data             (pop_data),
        .bins_in_use        (biu_reg),
        .clr_busy           (clr_busy),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_in_range         (m_in_range),
        .m_bin_index        (m_bin_index),
        .m_sum_of_x         (m_sum_of_x),
        .m_sum_of_y         (m_sum_of_y),
        .m_sum_of_y_squared (m_sum_of_y_squared),
        .m_hit_count        (m_hit_count),
        .m_closed_events    (m_closed_events)
    );

    `EHA_ASSERT_NOW(a_no_req_in_clear, clr_busy, !s_ready, "request taken during clear")
    `EHA_ASSERT_NOW(a_no_q_overflow, q_push, !q_full, "push into full queue")
    `EHA_ASSERT_NOW(a_no_q_underflow, q_pop, !q_empty, "pop from empty queue")
    `EHA_ASSERT_NOW(a_no_pop_in_clear, clr_busy, !q_pop, "request run during clear")

endmodule

@@ dv/tb_event_histogram_accumulator.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Event histogram accumulator testbench
// Drives fill, close and read requests with random sender bursts and receiver
// stalls, predicts every result in a scoreboard and checks it field by field.
// ---------------------------------------------------------------------------
import eha_pkg::*;

class hist_scoreboard;
    typedef struct {
        logic         in_range;
        logic [5:0]   bin_index;
        logic [47:0]  sum_x;
        logic [47:0]  sum_y;
        logic [63:0]  sum_ysq;
        logic [31:0]  hits;
        logic [31:0]  closed;
    } result_t;

    localparam int NB = 64;
    longint      x_sum [NB];
    longint      ev_y [NB];
    longint      tot_y [NB];
    bit [63:0]   tot_ysq [NB];
    bit [31:0]   hits [NB];
    bit [31:0]   events;
    longint      lo_edge;
    bit [31:0]   inv_width;
    bit [6:0]    used_bins;
    result_t     pending [$];
    int          errors;

    function new();
        for (int i = 0; i < NB; i++) begin
            x_sum[i] = 0; ev_y[i] = 0; tot_y[i] = 0; tot_ysq[i] = 0; hits[i] = 0;
        end
        events = 0; lo_edge = 0; inv_width = 65536; used_bins = 64; errors = 0;
    endfunction

    function longint clamp48(longint v);
        longint hi;
        hi = 64'sd140737488355327;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == CFG_BIN_MIN) lo_edge = longint'($signed(val));
        else if (idx == CFG_BIN_INV_WIDTH) inv_width = val;
        else if (idx == CFG_BINS_IN_USE) used_bins = val[6:0];
    endfunction

    function void note_request(logic [1:0] mode, logic signed [31:0] x,
                               logic signed [31:0] y, logic [5:0] sel);
        result_t r;
        longint diff;
        bit ok;
        bit [95:0] prod;
        bit [63:0] bin, mag;
        int n;
        r = '{default: '0};
        n = (used_bins > NB) ? NB : used_bins;
        if (mode == MODE_FILL) begin
            diff = longint'(x) - lo_edge;
            ok = 0; bin = 0;
            if (diff >= 0) begin
                prod = 96'(diff) * 96'(inv_width);
                bin = prod[95:32];
                ok = 1;
            end else if (inv_width == 0) ok = 1;
            if (ok && bin < n) begin
                x_sum[bin] = clamp48(x_sum[bin] + x);
                ev_y[bin] = clamp48(ev_y[bin] + y);
                if (hits[bin] != '1) hits[bin]++;
                r.in_range = 1;
                r.bin_index = bin[5:0];
            end
        end else if (mode == MODE_CLOSE) begin
            if (events != '1) events++;
            for (int i = 0; i < n; i++) begin
                mag = (ev_y[i] < 0) ? -ev_y[i] : ev_y[i];
                mag = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
                tot_y[i] = clamp48(tot_y[i] + ev_y[i]);
                tot_ysq[i] = (tot_ysq[i] + mag < tot_ysq[i]) ? '1 : tot_ysq[i] + mag;
                ev_y[i] = 0;
            end
            r.in_range = 1;
        end else if (mode == MODE_READ) begin
            r.bin_index = sel;
            r.in_range = 1;
            r.sum_x = x_sum[sel][47:0];
            r.sum_y = tot_y[sel][47:0];
            r.sum_ysq = tot_ysq[sel];
            r.hits = hits[sel];
        end
        r.closed = events;
        pending.push_back(r);
    endfunction

    function void check_result(logic in_range, logic [5:0] bin_index,
                               logic [47:0] sx, logic [47:0] sy, logic [63:0] sq,
                               logic [31:0] hc, logic [31:0] ce);
        result_t e;
        if (pending.size() == 0) begin
            $error("unexpected result");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (in_range !== e.in_range) begin
            $error("in_range exp %0h got %0h", e.in_range, in_range); errors++;
        end
        if (bin_index !== e.bin_index) begin
            $error("bin_index exp %0h got %0h", e.bin_index, bin_index); errors++;
        end
        if (sx !== e.sum_x) begin
            $error("sum_of_x exp %0h got %0h", e.sum_x, sx); errors++;
        end
        if (sy !== e.sum_y) begin
            $error("sum_of_y exp %0h got %0h", e.sum_y, sy); errors++;
        end
        if (sq !== e.sum_ysq) begin
            $error("sum_of_y_squared exp %0h got %0h", e.sum_ysq, sq); errors++;
        end
        if (hc !== e.hits) begin
            $error("hit_count exp %0h got %0h", e.hits, hc); errors++;
        end
        if (ce !== e.closed) begin
            $error("closed_events exp %0h got %0h", e.closed, ce); errors++;
        end
    endfunction
endclass

module tb_event_histogram_accumulator;
    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_mode = MODE_FILL;
    logic signed [31:0] s_x_value = 0;
    logic signed [31:0] s_y_value = 0;
    logic [5:0]         s_bin_select = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic               m_in_range;
    logic [5:0]         m_bin_index;
    logic signed [47:0] m_sum_of_x;
    logic signed [47:0] m_sum_of_y;
    logic [63:0]        m_sum_of_y_squared;
    logic [31:0]        m_hit_count;
    logic [31:0]        m_closed_events;
    logic               cfg_wr_en = 0;
    logic [1:0]         cfg_index = CFG_BIN_MIN;
    logic [31:0]        cfg_wr_data = 0;

    hist_scoreboard hist_sb = new();
    int unsigned    cycle_count = 0;
    int             stall_mode = 0;
    int             gap_left = 0;

    event_histogram_accumulator dut (.*);

    always #10 aclk = ~aclk;

    // sample handshakes at the rising edge
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready)
            hist_sb.check_result(m_in_range, m_bin_index, m_sum_of_x, m_sum_of_y,
                                 m_sum_of_y_squared, m_hit_count, m_closed_events);
        if (cycle_count > 2000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: phases of always-ready, random, and long stalls
    always @(negedge aclk) begin
        if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1;
            1: m_ready <= ($urandom & 3) != 0;
            default: m_ready <= ($urandom & 7) == 0;
        endcase
    end

    // valid stays high across back-to-back requests; it drops only for a gap
    task automatic send_request(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                                logic [5:0] sel);
        if (gap_left == 0 && ($urandom & 7) == 0) gap_left = $urandom_range(1, 12);
        if (gap_left > 0) s_valid <= 0;
        while (gap_left > 0) begin
            @(negedge aclk);
            gap_left--;
        end
        s_valid <= 1;
        s_mode <= mode;
        s_x_value <= x;
        s_y_value <= y;
        s_bin_select <= sel;
        do @(posedge aclk); while (!(s_valid && s_ready));
        hist_sb.note_request(mode, x, y, sel);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (hist_sb.pending.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        hist_sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_x();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h0048_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0, 1: send_request(MODE_CLOSE, $urandom, $urandom, $urandom);
                2, 3, 4: send_request(MODE_READ, $urandom, $urandom, $urandom);
                5: send_request(2'd3, $urandom, $urandom, $urandom);
                default: send_request(MODE_FILL, rand_x(),
                                      ($urandom & 1) ? $urandom : $urandom_range(0, 32'h3_0000),
                                      $urandom);
            endcase
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, every mode, floor below minimum, saturation
        send_request(MODE_FILL, 32'h0000_0000, 32'h0001_0000, 0);
        send_request(MODE_FILL, 32'h003F_FFFF, 32'h7FFF_FFFF, 0);
        send_request(MODE_FILL, 32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_request(MODE_FILL, 32'h0040_0000, 32'h1234_5678, 0);
        send_request(MODE_FILL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(MODE_FILL, 32'h8000_0000, 32'h0, 0);
        send_request(MODE_CLOSE, 0, 0, 0);
        send_request(MODE_READ, 0, 0, 0);
        send_request(MODE_READ, 0, 0, 63);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        repeat (3) send_request(MODE_FILL, 32'h0000_8000, 32'h7FFF_FFFF, 0);
        send_request(MODE_CLOSE, 0, 0, 0);
        send_request(MODE_READ, 0, 0, 0);
        drain();

        // zero reciprocal maps all x to bin 0, single bin in use
        write_reg(CFG_BIN_INV_WIDTH, 32'd0);
        write_reg(CFG_BINS_IN_USE, 7'd1);
        write_reg(CFG_BIN_MIN, 32'h7FFF_FFFF);
        send_request(MODE_FILL, 32'h8000_0000, 32'h8000_0000, 0);
        send_request(MODE_FILL, 32'h0001_0000, 32'h0001_0000, 0);
        send_request(MODE_CLOSE, 0, 0, 0);
        send_request(MODE_READ, 0, 0, 0);
        random_phase(150);
        drain();

        // no bins in use
        write_reg(CFG_BINS_IN_USE, 7'd0);
        write_reg(CFG_BIN_INV_WIDTH, 32'hFFFF_FFFF);
        write_reg(CFG_BIN_MIN, 32'h8000_0000);
        random_phase(100);
        drain();

        // oversize bin count clamps, narrow bins
        write_reg(CFG_BINS_IN_USE, 7'd127);
        write_reg(CFG_BIN_INV_WIDTH, 32'h0008_0000);
        write_reg(CFG_BIN_MIN, 32'hFFFC_0000);
        random_phase(300);
        drain();

        write_reg(CFG_BINS_IN_USE, 7'd5);
        write_reg(CFG_BIN_INV_WIDTH, 32'h0000_4000);
        write_reg(CFG_BIN_MIN, 32'h0);
        random_phase(250);
        drain();

        write_reg(CFG_BINS_IN_USE, 7'd64);
        write_reg(CFG_BIN_INV_WIDTH, 32'd65536);
        write_reg(CFG_BIN_MIN, 32'hFFFF_0000);
        random_phase(300);
        drain();

        if (hist_sb.errors == 0 && hist_sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/eha_pkg.sv
hw/rtl/eha_ram.sv
hw/rtl/eha_queue.sv
hw/rtl/eha_front.sv
hw/rtl/eha_back.sv
hw/rtl/event_histogram_accumulator.sv
dv/tb_event_histogram_accumulator.sv
